/* sv/bsl_pkg.sv */
package bsl_pkg;

    // Sizes of the board, the classes and the class lists
    localparam int NUM_SQUARES    = 64;
    localparam int NUM_CLASSES    = 12;
    localparam int CLASS_CAPACITY = 16;

    // Fixed field widths
    localparam int OP_W   = 3;
    localparam int CLS_W  = 4;
    localparam int SQ_W   = 6;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;
    localparam int SLOT_W = 4;

    // Derived storage widths
    localparam int SQ_AW     = (NUM_SQUARES > 1) ? $clog2(NUM_SQUARES) : 1;
    localparam int CLS_AW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int ENT_DEPTH = NUM_CLASSES * CLASS_CAPACITY;
    localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_MOVE   = 3'd3;
    localparam logic [OP_W-1:0] OP_CHANGE = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OCCUPIED = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // Input word
    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [CLS_W-1:0] piece_class;
        logic [SQ_W-1:0]  square;
        logic [SQ_W-1:0]  to_square;
    } t_in;

    // Result word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  list_count;
        logic [SLOT_W-1:0] slot_index;
        logic [SQ_W-1:0]   relocated_square;
    } t_out;

    // One square map entry
    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [SLOT_W-1:0] slot;
    } t_sq_info;

    // Square map write
    typedef struct packed {
        logic             en;
        logic [SQ_AW-1:0] addr;
        t_sq_info         info;
    } t_sq_wr;

    // Occupancy update
    typedef struct packed {
        logic             clear;
        logic             set_en;
        logic [SQ_AW-1:0] set_addr;
        logic             clr_en;
        logic [SQ_AW-1:0] clr_addr;
    } t_occ_upd;

    // Class count write
    typedef struct packed {
        logic             clear;
        logic             en;
        logic [CLS_W-1:0] addr;
        logic [CNT_W-1:0] cnt;
    } t_cnt_wr;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_TAKE,
        S_PUT,
        S_OUT
    } t_state;

    // Flat address of one slot of one class list
    function automatic logic [ENT_AW-1:0] ent_addr(input logic [CLS_W-1:0]  cls,
                                                   input logic [SLOT_W-1:0] idx);
        return ENT_AW'(int'(cls) * CLASS_CAPACITY + int'(idx));
    endfunction

endpackage

/* sv/bsl_ram.sv */
module bsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/bsl_sq_map.sv */
module bsl_sq_map
    import bsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SQ_AW-1:0] i_rd_addr,
    output t_sq_info         o_rd_info,
    input  t_sq_wr           i_wr,
    input  t_occ_upd         i_occ,
    input  logic [SQ_AW-1:0] i_look_a,
    input  logic [SQ_AW-1:0] i_look_b,
    output logic             o_occ_a,
    output logic             o_occ_b
);

    logic [NUM_SQUARES-1:0]     r_occ;
    logic                       r_rd_occ;
    logic [$bits(t_sq_info)-1:0] ram_rd;

    // Class and slot of each square
    bsl_ram #(
        .WIDTH ($bits(t_sq_info)),
        .DEPTH (NUM_SQUARES)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr.en),
        .i_wr_addr (i_wr.addr),
        .i_wr_data (i_wr.info),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_rd)
    );

    // Occupancy flags, cleared at once by reset or clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_occ.clear) begin
            r_occ <= '0;
        end else begin
            for (int i = 0; i < NUM_SQUARES; i++) begin
                if (i_occ.clr_en && int'(i_occ.clr_addr) == i) begin
                    r_occ[i] <= 1'b0;
                end
                if (i_occ.set_en && int'(i_occ.set_addr) == i) begin
                    r_occ[i] <= 1'b1;
                end
            end
        end
    end

    // Flag follows the read so an empty square reads as zero
    always_ff @(posedge i_clk) begin
        r_rd_occ <= r_occ[i_rd_addr];
    end

    assign o_rd_info = r_rd_occ ? t_sq_info'(ram_rd) : '0;
    assign o_occ_a   = r_occ[i_look_a];
    assign o_occ_b   = r_occ[i_look_b];

endmodule

/* sv/bsl_count_file.sv */
module bsl_count_file
    import bsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CLS_W-1:0] i_rd_addr,
    output logic [CNT_W-1:0] o_rd_cnt,
    input  t_cnt_wr          i_wr
);

    logic [CNT_W-1:0] r_cnt [NUM_CLASSES];

    // List lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clear) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_wr.en && int'(i_wr.addr) < NUM_CLASSES) begin
            r_cnt[i_wr.addr[CLS_AW-1:0]] <= i_wr.cnt;
        end
    end

    // A class number beyond the number of classes reads as empty
    assign o_rd_cnt = (int'(i_rd_addr) < NUM_CLASSES) ? r_cnt[i_rd_addr[CLS_AW-1:0]] : '0;

endmodule

/* sv/bucketed_square_list.sv */
// Per-class lists of occupied squares with a reverse map from square to class and slot.
// One word is worked at a time: o_in_ready is high only while the sequencer is idle.
// From acceptance, clear, add, move, errors and unused codes pass S_LOOK and S_OUT;
// remove adds S_TAKE and change adds S_TAKE and S_PUT. S_OUT holds while o_out is not
// free. The steps follow the square map RAM (registered read, then write back) and,
// for swap-remove, a read of the entry RAM for the last entry of the list. The result
// sits in an output register, so the next word is taken while a result still waits on
// o_out. Reset and clear empty all lists at once through occupancy flags and count
// registers; there is no clearing pass. Error results leave the state unchanged.
module bucketed_square_list
    import bsl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_state r_state, n_state;

    logic [OP_W-1:0]   r_op, n_op;
    logic [CLS_W-1:0]  r_cls, n_cls;
    logic [SQ_W-1:0]   r_sq, n_sq;
    logic [SQ_W-1:0]   r_to, n_to;
    logic              r_sq_rng, n_sq_rng;
    logic              r_sq_occ, n_sq_occ;
    logic              r_to_rng, n_to_rng;
    logic              r_to_occ, n_to_occ;
    logic [CNT_W-1:0]  r_cnt_cls, n_cnt_cls;
    logic [CLS_W-1:0]  r_old, n_old;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_last, n_last;
    t_out              r_res, n_res;
    logic              r_out_valid;
    t_out              r_out;

    // Storage ports
    logic [SQ_AW-1:0]  sq_rd_addr;
    t_sq_info          sq_rd;
    t_sq_wr            sq_wr;
    t_occ_upd          occ_upd;
    logic              occ_a, occ_b;
    logic [CLS_W-1:0]  cnt_rd_addr;
    logic [CNT_W-1:0]  cnt_rd;
    t_cnt_wr           cnt_wr;
    logic              ent_we;
    logic [ENT_AW-1:0] ent_wa;
    logic [SQ_W-1:0]   ent_wd;
    logic [ENT_AW-1:0] ent_ra;
    logic [SQ_W-1:0]   ent_rd;

    // Helpers
    logic              out_free;
    logic              cls_ok;
    logic [CNT_W-1:0]  cnt_dec;
    logic [SLOT_W-1:0] last_look;
    logic [CNT_W-1:0]  avail;
    logic              relocate;
    logic [SLOT_W-1:0] nidx;

    bsl_sq_map u_sq_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (sq_rd_addr),
        .o_rd_info (sq_rd),
        .i_wr      (sq_wr),
        .i_occ     (occ_upd),
        .i_look_a  (i_in.square[SQ_AW-1:0]),
        .i_look_b  (i_in.to_square[SQ_AW-1:0]),
        .o_occ_a   (occ_a),
        .o_occ_b   (occ_b)
    );

    bsl_count_file u_counts (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (cnt_rd_addr),
        .o_rd_cnt  (cnt_rd),
        .i_wr      (cnt_wr)
    );

    // List contents, all classes in one memory
    bsl_ram #(
        .WIDTH (SQ_W),
        .DEPTH (ENT_DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (ent_we),
        .i_wr_addr (ent_wa),
        .i_wr_data (ent_wd),
        .i_rd_addr (ent_ra),
        .o_rd_data (ent_rd)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    // Read addresses: the incoming word while idle, the source class during lookup
    assign sq_rd_addr  = i_in.square[SQ_AW-1:0];
    assign cnt_rd_addr = (r_state == S_LOOK) ? sq_rd.cls : i_in.piece_class;

    assign cls_ok    = int'(r_cls) < NUM_CLASSES;
    assign cnt_dec   = cnt_rd - CNT_W'(1);
    assign last_look = cnt_dec[SLOT_W-1:0];
    assign ent_ra    = ent_addr(sq_rd.cls, last_look);
    assign avail     = (r_cls == sq_rd.cls) ? r_cnt_cls - CNT_W'(1) : r_cnt_cls;
    assign relocate  = (r_idx != r_last);
    assign nidx      = (r_cls == r_old) ? r_last : r_cnt_cls[SLOT_W-1:0];

    // State and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_cls     <= n_cls;
        r_sq      <= n_sq;
        r_to      <= n_to;
        r_sq_rng  <= n_sq_rng;
        r_sq_occ  <= n_sq_occ;
        r_to_rng  <= n_to_rng;
        r_to_occ  <= n_to_occ;
        r_cnt_cls <= n_cnt_cls;
        r_old     <= n_old;
        r_idx     <= n_idx;
        r_last    <= n_last;
        r_res     <= n_res;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end

    // Sequencer: look up, check, then read-modify-write the lists and maps
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cls     = r_cls;
        n_sq      = r_sq;
        n_to      = r_to;
        n_sq_rng  = r_sq_rng;
        n_sq_occ  = r_sq_occ;
        n_to_rng  = r_to_rng;
        n_to_occ  = r_to_occ;
        n_cnt_cls = r_cnt_cls;
        n_old     = r_old;
        n_idx     = r_idx;
        n_last    = r_last;
        n_res     = r_res;

        ent_we      = 1'b0;
        ent_wa      = '0;
        ent_wd      = '0;
        sq_wr       = '0;
        occ_upd     = '0;
        cnt_wr      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in.operation;
                    n_cls     = i_in.piece_class;
                    n_sq      = i_in.square;
                    n_to      = i_in.to_square;
                    n_sq_rng  = int'(i_in.square) < NUM_SQUARES;
                    n_sq_occ  = occ_a && (int'(i_in.square) < NUM_SQUARES);
                    n_to_rng  = int'(i_in.to_square) < NUM_SQUARES;
                    n_to_occ  = occ_b && (int'(i_in.to_square) < NUM_SQUARES);
                    n_cnt_cls = cnt_rd;
                    n_state   = S_LOOK;
                end
            end

            S_LOOK: begin
                n_old       = sq_rd.cls;
                n_idx       = sq_rd.slot;
                n_last      = last_look;
                n_res       = '0;
                n_state     = S_OUT;
                case (r_op)
                    OP_CLEAR: begin
                        occ_upd.clear = 1'b1;
                        cnt_wr.clear  = 1'b1;
                    end
                    OP_ADD: begin
                        n_res.list_count = r_cnt_cls;
                        if (!r_sq_rng || r_sq_occ) begin
                            n_res.status = ST_OCCUPIED;
                        end else if (!cls_ok || r_cnt_cls >= CNT_W'(CLASS_CAPACITY)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            ent_we           = 1'b1;
                            ent_wa           = ent_addr(r_cls, r_cnt_cls[SLOT_W-1:0]);
                            ent_wd           = r_sq;
                            sq_wr.en         = 1'b1;
                            sq_wr.addr       = r_sq[SQ_AW-1:0];
                            sq_wr.info.cls   = r_cls;
                            sq_wr.info.slot  = r_cnt_cls[SLOT_W-1:0];
                            occ_upd.set_en   = 1'b1;
                            occ_upd.set_addr = r_sq[SQ_AW-1:0];
                            cnt_wr.en        = 1'b1;
                            cnt_wr.addr      = r_cls;
                            cnt_wr.cnt       = r_cnt_cls + CNT_W'(1);
                            n_res.list_count = r_cnt_cls + CNT_W'(1);
                            n_res.slot_index = r_cnt_cls[SLOT_W-1:0];
                        end
                    end
                    OP_REMOVE: begin
                        if (!r_sq_occ) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_state = S_TAKE;
                        end
                    end
                    OP_MOVE: begin
                        if (!r_sq_occ) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_res.list_count = cnt_rd;
                            if (!r_to_rng || r_to_occ) begin
                                n_res.status = ST_OCCUPIED;
                            end else begin
                                ent_we           = 1'b1;
                                ent_wa           = ent_addr(sq_rd.cls, sq_rd.slot);
                                ent_wd           = r_to;
                                sq_wr.en         = 1'b1;
                                sq_wr.addr       = r_to[SQ_AW-1:0];
                                sq_wr.info       = sq_rd;
                                occ_upd.set_en   = 1'b1;
                                occ_upd.set_addr = r_to[SQ_AW-1:0];
                                occ_upd.clr_en   = 1'b1;
                                occ_upd.clr_addr = r_sq[SQ_AW-1:0];
                                n_res.slot_index = sq_rd.slot;
                            end
                        end
                    end
                    OP_CHANGE: begin
                        if (!r_sq_occ) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_res.list_count = r_cnt_cls;
                            if (!r_to_rng || (r_to_occ && r_to != r_sq)) begin
                                n_res.status = ST_OCCUPIED;
                            end else if (!cls_ok || avail >= CNT_W'(CLASS_CAPACITY)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_state = S_TAKE;
                            end
                        end
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end

            S_TAKE: begin
                // Last entry fills the freed slot
                if (relocate) begin
                    ent_we          = 1'b1;
                    ent_wa          = ent_addr(r_old, r_idx);
                    ent_wd          = ent_rd;
                    sq_wr.en        = 1'b1;
                    sq_wr.addr      = ent_rd[SQ_AW-1:0];
                    sq_wr.info.cls  = r_old;
                    sq_wr.info.slot = r_idx;
                end
                occ_upd.clr_en   = 1'b1;
                occ_upd.clr_addr = r_sq[SQ_AW-1:0];
                cnt_wr.en        = 1'b1;
                cnt_wr.addr      = r_old;
                cnt_wr.cnt       = CNT_W'(r_last);
                n_res.relocated_square = relocate ? ent_rd : '0;
                if (r_op == OP_REMOVE) begin
                    n_res.status     = ST_OK;
                    n_res.list_count = CNT_W'(r_last);
                    n_res.slot_index = r_idx;
                    n_state          = S_OUT;
                end else begin
                    n_state = S_PUT;
                end
            end

            S_PUT: begin
                // Append the destination under the new class
                ent_we           = 1'b1;
                ent_wa           = ent_addr(r_cls, nidx);
                ent_wd           = r_to;
                sq_wr.en         = 1'b1;
                sq_wr.addr       = r_to[SQ_AW-1:0];
                sq_wr.info.cls   = r_cls;
                sq_wr.info.slot  = nidx;
                occ_upd.set_en   = 1'b1;
                occ_upd.set_addr = r_to[SQ_AW-1:0];
                cnt_wr.en        = 1'b1;
                cnt_wr.addr      = r_cls;
                cnt_wr.cnt       = CNT_W'(nidx) + CNT_W'(1);
                n_res.status     = ST_OK;
                n_res.list_count = CNT_W'(nidx) + CNT_W'(1);
                n_res.slot_index = nidx;
                n_state          = S_OUT;
            end

            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Checks
    a_put_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> ($past(r_state) == S_TAKE))
        else $error("append step not preceded by swap-remove");

    a_take_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAKE) |-> r_sq_occ)
        else $error("swap-remove of an empty square");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_wr.en |-> (cnt_wr.cnt <= CNT_W'(CLASS_CAPACITY)))
        else $error("class count beyond capacity");

    a_occ_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (occ_upd.set_en && occ_upd.clr_en) |-> (occ_upd.set_addr != occ_upd.clr_addr))
        else $error("square set and cleared in one cycle");

endmodule
